// ===== hdl/sodg_pkg.sv =====
// ----------------------------------------------------------------------------
// sodg_pkg
// Shared types, codes and constants of the seeded ordered draw generator.
// ----------------------------------------------------------------------------
package sodg_pkg;

    // Generator family codes
    typedef enum logic [2:0] {
        FAM_LCG48    = 3'd0,
        FAM_LCG32    = 3'd1,
        FAM_LCG31    = 3'd2,
        FAM_XS32     = 3'd3,
        FAM_XS64S    = 3'd4,
        FAM_SPLITMIX = 3'd5,
        FAM_PCG32    = 3'd6,
        FAM_LCG64    = 3'd7
    } fam_t;

    // Sampler codes
    typedef enum logic [1:0] {
        MODE_MOD_REJ  = 2'd0,
        MODE_MUL_REJ  = 2'd1,
        MODE_SHUF_MOD = 2'd2,
        MODE_SHUF_MUL = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    localparam logic REG_GEN_FAMILY   = 1'b0;
    localparam logic REG_SAMPLER_MODE = 1'b1;

    // Generator constants
    localparam logic [63:0] LCG48_MUL  = 64'h0000_0005_DEEC_E66D;
    localparam logic [63:0] LCG48_INC  = 64'hB;
    localparam logic [63:0] LCG48_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] LCG32_MUL  = 64'd214013;
    localparam logic [63:0] LCG32_INC  = 64'd2531011;
    localparam logic [63:0] LCG31_MUL  = 64'd1103515245;
    localparam logic [63:0] LCG31_INC  = 64'd12345;
    localparam logic [63:0] LCG31_MASK = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] XS64_MUL   = 64'd2685821657736338717;
    localparam logic [63:0] SM_GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2    = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] LCG64_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] LCG64_INC  = 64'd1442695040888963407;
    localparam logic [63:0] PCG_INC    = LCG64_INC | 64'd1;
    localparam int          NARROW_SHIFT = 15;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MSEL_GEN1  = 2'd0,
        MSEL_GEN2  = 2'd1,
        MSEL_SCALE = 2'd2
    } mul_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE, S_GEN_PRE, S_MUL1, S_MUL1_WAIT, S_GEN_POST, S_MUL2, S_MUL2_WAIT,
        S_GEN_FIN, S_SCALE, S_SCALE_WAIT, S_PICK, S_ARR_RD, S_SWAP, S_CHECK,
        S_OUT_RD, S_OUT_SEND
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     gen_pre;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     gen_post;
        logic     gen_fin;
        logic     div_start;
        logic     idx_cap;
        logic     pick;
        logic     arr_rd;
        logic     swap;
        logic     out_rd;
        logic     out_next;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic got_full;
        logic steps_full;
        logic out_last;
    } status_t;

    function automatic logic is_shuffle(mode_t m);
        return (m == MODE_SHUF_MOD) || (m == MODE_SHUF_MUL);
    endfunction

    function automatic logic uses_mul(mode_t m);
        return (m == MODE_MUL_REJ) || (m == MODE_SHUF_MUL);
    endfunction

    function automatic logic [31:0] xs32_step(logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [63:0] xs64_step(logic [63:0] v);
        logic [63:0] t;
        t = v ^ (v >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    function automatic logic [31:0] pcg_out(logic [63:0] old);
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        t   = ((old >> 18) ^ old) >> 27;
        xs  = t[31:0];
        rot = old[63:59];
        return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    endfunction

endpackage

// ===== hdl/sodg_mul.sv =====
// ----------------------------------------------------------------------------
// sodg_mul
// 64 x 64 multiplier, low 64 bits of the product, built from one 32 x 32
// multiplier reused over the phases LL, LH, HL and LAST.
// ----------------------------------------------------------------------------
module sodg_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LL   = 3'd1;
    localparam logic [2:0] PH_LH   = 3'd2;
    localparam logic [2:0] PH_HL   = 3'd3;
    localparam logic [2:0] PH_LAST = 3'd4;

    logic [2:0]  ph_reg;
    logic        done_reg;
    logic [63:0] a_reg, b_reg, prod_reg, acc_reg;
    logic [31:0] op_a, op_b;

    // Pick the partial product for this phase
    always_comb begin
        op_a = (ph_reg == PH_HL) ? a_reg[63:32] : a_reg[31:0];
        op_b = (ph_reg == PH_LH) ? b_reg[63:32] : b_reg[31:0];
    end

    // Advance the phase counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ph_reg <= PH_LL;
            end else if (ph_reg == PH_LAST) begin
                ph_reg   <= PH_IDLE;
                done_reg <= 1'b1;
            end else if (ph_reg != PH_IDLE) begin
                ph_reg <= ph_reg + 3'd1;
            end
        end
    end

    // Multiply and accumulate
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= {32'd0, op_a} * {32'd0, op_b};
        case (ph_reg)
            PH_LH:   acc_reg <= prod_reg;
            PH_HL:   acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            PH_LAST: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            default: acc_reg <= acc_reg;
        endcase
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== hdl/sodg_div.sv =====
// ----------------------------------------------------------------------------
// sodg_div
// Restoring remainder unit: 32-bit word modulo a small divisor, one bit per
// cycle.
// ----------------------------------------------------------------------------
module sodg_div #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [DW-1:0] rem
);
    logic [5:0]    cnt_reg;
    logic          done_reg;
    logic [31:0]   q_reg;
    logic [DW-1:0] rem_reg, den_reg, rem_next;
    logic [DW:0]   trial;

    // One restoring step
    always_comb begin
        trial = {rem_reg, q_reg[31]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = DW'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[DW-1:0];
        end
    end

    // Count the steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'd32;
            end else if (cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    // Shift the dividend through the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (cnt_reg != 6'd0) begin
            q_reg   <= {q_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hdl/sodg_dp.sv =====
// ----------------------------------------------------------------------------
// sodg_dp
// Datapath: generator state, scaling units, used marks, shuffle array and
// draw buffer.
// ----------------------------------------------------------------------------
module sodg_dp
    import sodg_pkg::*;
#(
    parameter int POOL_SIZE  = 80,
    parameter int DRAW_COUNT = 20,
    parameter int STEP_LIMIT = 4000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  fam_t        fam,
    input  mode_t       mode,
    input  logic [63:0] seed,
    output status_t     status,
    output logic [6:0]  draw_number,
    output logic [4:0]  draw_position,
    output logic        short_draw
);
    localparam int CNT    = (DRAW_COUNT < POOL_SIZE) ? DRAW_COUNT : POOL_SIZE;
    localparam int RNG_W  = $clog2(POOL_SIZE + 1);
    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(CNT + 1);
    localparam int NAW    = (CNT > 1) ? $clog2(CNT) : 1;
    localparam int STEP_W = $clog2(STEP_LIMIT + 1);

    logic [63:0]          st_reg, x_reg, st_next, x_next;
    logic [31:0]          word_reg, word_next;
    logic [RNG_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     got_reg, k_reg;
    logic [STEP_W-1:0]    steps_reg;
    logic [POOL_SIZE-1:0] mark_reg;
    logic [RNG_W-1:0]     nums_mem [CNT];
    logic [RNG_W-1:0]     arr_mem  [POOL_SIZE];
    logic [RNG_W-1:0]     rd_i_reg, rd_j_reg, num_reg;
    logic                 vld_i_reg, vld_j_reg, num_ok_reg;
    logic [IDX_W-1:0]     i_q_reg, j_q_reg;

    logic [63:0]      mul_a, mul_b, mul_p, t64;
    logic             mul_done, div_done;
    logic [RNG_W-1:0] range, div_rem, mul_idx, p_eff, ai, aj;
    logic [IDX_W-1:0] i_addr, j_addr;
    logic             pick_ok;
    logic             nums_we;
    logic [NAW-1:0]   nums_wa;
    logic [RNG_W-1:0] nums_wd;

    // Sampling range and scaled index
    always_comb begin
        range   = is_shuffle(mode) ? (RNG_W'(POOL_SIZE) - RNG_W'(got_reg))
                                   : RNG_W'(POOL_SIZE);
        mul_idx = (fam == FAM_LCG32) ? RNG_W'(mul_p >> NARROW_SHIFT)
                                     : RNG_W'(mul_p >> 32);
        p_eff   = (idx_reg >= range) ? (range - RNG_W'(1)) : idx_reg;
        i_addr  = IDX_W'(got_reg);
        j_addr  = IDX_W'(RNG_W'(got_reg) + p_eff);
        pick_ok = cmd.pick && (idx_reg < RNG_W'(POOL_SIZE))
                  && !mark_reg[IDX_W'(idx_reg)];
        ai      = vld_i_reg ? rd_i_reg : (RNG_W'(i_q_reg) + RNG_W'(1));
        aj      = vld_j_reg ? rd_j_reg : (RNG_W'(j_q_reg) + RNG_W'(1));
    end

    // Multiplier operands
    always_comb begin
        mul_a = (cmd.mul_sel == MSEL_SCALE) ? {32'd0, word_reg} : x_reg;
        case (cmd.mul_sel)
            MSEL_GEN1: begin
                case (fam)
                    FAM_LCG48:    mul_b = LCG48_MUL;
                    FAM_LCG32:    mul_b = LCG32_MUL;
                    FAM_LCG31:    mul_b = LCG31_MUL;
                    FAM_XS64S:    mul_b = XS64_MUL;
                    FAM_SPLITMIX: mul_b = SM_MUL1;
                    default:      mul_b = LCG64_MUL;
                endcase
            end
            MSEL_GEN2:  mul_b = SM_MUL2;
            MSEL_SCALE: mul_b = 64'(range);
            default:    mul_b = '0;
        endcase
    end

    sodg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    sodg_div #(.DW(RNG_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (word_reg),
        .den     (range),
        .done    (div_done),
        .rem     (div_rem)
    );

    // Generator state update
    always_comb begin
        st_next   = st_reg;
        x_next    = x_reg;
        word_next = word_reg;
        t64       = '0;
        if (cmd.load) begin
            case (fam)
                FAM_LCG48: st_next = (seed ^ LCG48_MUL) & LCG48_MASK;
                FAM_LCG32: st_next = {32'd0, seed[31:0]};
                FAM_LCG31: st_next = seed & LCG31_MASK;
                FAM_XS32:  st_next = (seed[31:0] == 32'd0) ? 64'd1 : {32'd0, seed[31:0]};
                FAM_XS64S: st_next = (seed == 64'd0) ? 64'd1 : seed;
                default:   st_next = seed;
            endcase
        end else if (cmd.gen_pre) begin
            case (fam)
                FAM_XS32: begin
                    word_next = xs32_step(st_reg[31:0]);
                    st_next   = {32'd0, word_next};
                end
                FAM_XS64S: begin
                    st_next = xs64_step(st_reg);
                    x_next  = st_next;
                end
                FAM_SPLITMIX: begin
                    t64     = st_reg + SM_GOLDEN;
                    st_next = t64;
                    x_next  = t64 ^ (t64 >> 30);
                end
                FAM_PCG32: begin
                    x_next    = st_reg;
                    word_next = pcg_out(st_reg);
                end
                default: x_next = st_reg;
            endcase
        end else if (cmd.gen_post) begin
            case (fam)
                FAM_LCG48: begin
                    t64       = (mul_p + LCG48_INC) & LCG48_MASK;
                    st_next   = t64;
                    word_next = t64[47:16];
                end
                FAM_LCG32: begin
                    t64       = {32'd0, mul_p[31:0] + LCG32_INC[31:0]};
                    st_next   = t64;
                    word_next = {17'd0, t64[30:16]};
                end
                FAM_LCG31: begin
                    t64       = (mul_p + LCG31_INC) & LCG31_MASK;
                    st_next   = t64;
                    word_next = t64[31:0];
                end
                FAM_XS64S:    word_next = mul_p[63:32];
                FAM_SPLITMIX: x_next    = mul_p ^ (mul_p >> 27);
                FAM_PCG32:    st_next   = mul_p + PCG_INC;
                FAM_LCG64: begin
                    t64       = mul_p + LCG64_INC;
                    st_next   = t64;
                    word_next = t64[63:32];
                end
                default: st_next = st_reg;
            endcase
        end else if (cmd.gen_fin) begin
            t64       = mul_p ^ (mul_p >> 31);
            word_next = t64[63:32];
        end
    end

    // Hold generator registers and the captured index
    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        x_reg    <= x_next;
        word_reg <= word_next;
        if (cmd.idx_cap) begin
            idx_reg <= uses_mul(mode) ? mul_idx : div_rem;
        end
    end

    // Draw bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            got_reg   <= '0;
            steps_reg <= '0;
            mark_reg  <= '0;
            k_reg     <= '0;
        end else if (cmd.load) begin
            got_reg   <= '0;
            steps_reg <= '0;
            mark_reg  <= '0;
            k_reg     <= '0;
        end else begin
            if (cmd.pick) begin
                steps_reg <= steps_reg + STEP_W'(1);
            end
            if (pick_ok) begin
                mark_reg[IDX_W'(idx_reg)] <= 1'b1;
                got_reg <= got_reg + CNT_W'(1);
            end
            if (cmd.swap) begin
                mark_reg[j_q_reg] <= 1'b1;
                got_reg <= got_reg + CNT_W'(1);
            end
            if (cmd.out_next) begin
                k_reg <= k_reg + CNT_W'(1);
            end
        end
    end

    // Shuffle array: two registered reads, one write
    always_ff @(posedge aclk) begin
        if (cmd.arr_rd) begin
            rd_i_reg  <= arr_mem[i_addr];
            rd_j_reg  <= arr_mem[j_addr];
            vld_i_reg <= mark_reg[i_addr];
            vld_j_reg <= mark_reg[j_addr];
            i_q_reg   <= i_addr;
            j_q_reg   <= j_addr;
        end
        if (cmd.swap) begin
            arr_mem[j_q_reg] <= ai;
        end
    end

    // Draw buffer write port
    always_comb begin
        nums_we = pick_ok || cmd.swap;
        nums_wa = NAW'(got_reg);
        nums_wd = cmd.swap ? aj : (idx_reg + RNG_W'(1));
    end

    // Draw buffer: one write, one registered read
    always_ff @(posedge aclk) begin
        if (nums_we) begin
            nums_mem[nums_wa] <= nums_wd;
        end
        if (cmd.out_rd) begin
            num_reg    <= nums_mem[NAW'(k_reg)];
            num_ok_reg <= (k_reg < got_reg);
        end
    end

    // Status and result fields
    always_comb begin
        status.mul_done   = mul_done;
        status.div_done   = div_done;
        status.got_full   = (got_reg == CNT_W'(CNT));
        status.steps_full = (steps_reg == STEP_W'(STEP_LIMIT));
        status.out_last   = (k_reg == CNT_W'(CNT - 1));
        draw_number       = num_ok_reg ? 7'(num_reg) : 7'd0;
        draw_position     = 5'(k_reg);
        short_draw        = (got_reg != CNT_W'(CNT));
    end

endmodule

// ===== hdl/sodg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sodg_ctrl
// Controller: sequences generator steps, scaling, selection and output.
// ----------------------------------------------------------------------------
module sodg_ctrl
    import sodg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  fam_t    fam,
    input  mode_t   mode,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MSEL_GEN1;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_GEN_PRE;
                end
            end
            S_GEN_PRE: begin
                cmd.gen_pre = 1'b1;
                state_next  = (fam == FAM_XS32) ? S_SCALE : S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_GEN1;
                state_next    = S_MUL1_WAIT;
            end
            S_MUL1_WAIT: begin
                if (status.mul_done) begin
                    state_next = S_GEN_POST;
                end
            end
            S_GEN_POST: begin
                cmd.gen_post = 1'b1;
                state_next   = (fam == FAM_SPLITMIX) ? S_MUL2 : S_SCALE;
            end
            S_MUL2: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_GEN2;
                state_next    = S_MUL2_WAIT;
            end
            S_MUL2_WAIT: begin
                if (status.mul_done) begin
                    state_next = S_GEN_FIN;
                end
            end
            S_GEN_FIN: begin
                cmd.gen_fin = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE: begin
                cmd.mul_sel = MSEL_SCALE;
                if (uses_mul(mode)) begin
                    cmd.mul_start = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                end
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT: begin
                if (uses_mul(mode) ? status.mul_done : status.div_done) begin
                    cmd.idx_cap = 1'b1;
                    state_next  = is_shuffle(mode) ? S_ARR_RD : S_PICK;
                end
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = S_CHECK;
            end
            S_ARR_RD: begin
                cmd.arr_rd = 1'b1;
                state_next = S_SWAP;
            end
            S_SWAP: begin
                cmd.swap   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (status.got_full || (!is_shuffle(mode) && status.steps_full)) begin
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_GEN_PRE;
                end
            end
            S_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_SEND;
            end
            S_OUT_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.out_next = 1'b1;
                    state_next   = status.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/seeded_ordered_draw_generator_core.sv =====
// ----------------------------------------------------------------------------
// seeded_ordered_draw_generator_core
// Turns a 64-bit seed into an ordered draw of distinct numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Write generator_family (address 0) and sampler_mode (address 4) over the
//   APB port while the block is idle. Send one seed per transfer on s_*.
//   The block answers with min(DRAW_COUNT, POOL_SIZE) transfers on m_*,
//   slot order, m_tlast on the final one; m_tuser flags a draw that the
//   rejection step limit ended early (unfilled slots carry number 0).
// Flow:
//   One seed at a time; s_tready is high only while idle. Each generator
//   word takes zero, one or two products on the shared 64-bit multiplier:
//   xorshift32 none, splitmix64 two and the other families one. Scaling
//   then uses the same multiplier (multiply-shift) or the bit-serial
//   remainder unit, and selection follows. Rejection retries add one word
//   each, up to STEP_LIMIT words in all.
// Reset:
//   aresetn clears both registers to 0 and returns the controller to idle.
//   A stalled m_tready holds the current result and pauses the block.
// ----------------------------------------------------------------------------
module seeded_ordered_draw_generator_core
    import sodg_pkg::*;
#(
    parameter int POOL_SIZE  = 80,
    parameter int DRAW_COUNT = 20,
    parameter int STEP_LIMIT = 4000
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Seed channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] draw_number, [11:7] draw_position, zero fill
    output logic        m_tuser,   // [0] short_draw
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    fam_t    fam_reg;
    mode_t   mode_reg;
    cmd_t    cmd;
    status_t status;
    logic    cfg_wr;
    logic [6:0] draw_number;
    logic [4:0] draw_position;
    logic       short_draw;

    // Register writes
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fam_reg  <= FAM_LCG48;
            mode_reg <= MODE_MOD_REJ;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GEN_FAMILY:   fam_reg  <= fam_t'(pwdata[2:0]);
                REG_SAMPLER_MODE: mode_reg <= mode_t'(pwdata[1:0]);
                default:          fam_reg  <= fam_reg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        pready = 1'b1;
        unique case (paddr[2])
            REG_GEN_FAMILY:   prdata = {29'd0, fam_reg};
            REG_SAMPLER_MODE: prdata = {30'd0, mode_reg};
            default:          prdata = '0;
        endcase
    end

    sodg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fam      (fam_reg),
        .mode     (mode_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sodg_dp #(
        .POOL_SIZE  (POOL_SIZE),
        .DRAW_COUNT (DRAW_COUNT),
        .STEP_LIMIT (STEP_LIMIT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .fam           (fam_reg),
        .mode          (mode_reg),
        .seed          (s_tdata),
        .status        (status),
        .draw_number   (draw_number),
        .draw_position (draw_position),
        .short_draw    (short_draw)
    );

    // Pack the result transfer
    assign m_tdata = {4'd0, draw_position, draw_number};
    assign m_tuser = short_draw;
    assign m_tlast = status.out_last;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seeded ordered draw generator core.
// Steps the register settings through every generator family and sampler,
// sends seeds on the stream input with random gaps and collects the draw
// results under random back-pressure. A built-in predictor computes each draw.
// Every result transfer is checked field by field against the oldest
// expected slot.
// ----------------------------------------------------------------------------
module tb
    import sodg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL  = 80;
    localparam int SLOTS = 20;
    localparam int LIMIT = 4000;

    typedef struct packed {
        logic [6:0] number;
        logic [4:0] position;
        logic       short_draw;
        logic       last;
    } slot_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fam_t        cur_fam = FAM_LCG48;
    mode_t       cur_mode = MODE_MOD_REJ;
    logic [63:0] seed_q[$];
    slot_t       slot_q[$];
    int          errors = 0;
    bit          calm = 1'b0;

    seeded_ordered_draw_generator_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Advance one generator and return its 32-bit word
    function automatic logic [31:0] next_word(input fam_t f, inout logic [63:0] st);
        logic [63:0] x;
        logic [31:0] xs;
        case (f)
            FAM_LCG48: begin
                st = (st * 64'h5DEECE66D + 64'hB) & 64'h0000_FFFF_FFFF_FFFF;
                return st[47:16];
            end
            FAM_LCG32: begin
                st = (st * 64'd214013 + 64'd2531011) & 64'hFFFF_FFFF;
                return {17'd0, st[30:16]};
            end
            FAM_LCG31: begin
                st = (st * 64'd1103515245 + 64'd12345) & 64'h7FFF_FFFF;
                return st[31:0];
            end
            FAM_XS32: begin
                xs = st[31:0];
                xs = xs ^ (xs << 13);
                xs = xs ^ (xs >> 17);
                xs = xs ^ (xs << 5);
                st = {32'd0, xs};
                return xs;
            end
            FAM_XS64S: begin
                x = st;
                x = x ^ (x >> 12);
                x = x ^ (x << 25);
                x = x ^ (x >> 27);
                st = x;
                x = x * 64'd2685821657736338717;
                return x[63:32];
            end
            FAM_SPLITMIX: begin
                st = st + 64'h9E37_79B9_7F4A_7C15;
                x = st;
                x = (x ^ (x >> 30)) * 64'hBF58_476D_1CE4_E5B9;
                x = (x ^ (x >> 27)) * 64'h94D0_49BB_1331_11EB;
                x = x ^ (x >> 31);
                return x[63:32];
            end
            FAM_PCG32: begin
                return pcg_word(st);
            end
            default: begin
                st = st * 64'd6364136223846793005 + 64'd1442695040888963407;
                return st[63:32];
            end
        endcase
    endfunction

    // Permuted output of pcg32 taken from the state before the step
    function automatic logic [31:0] pcg_word(inout logic [63:0] st);
        logic [63:0] old;
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        old = st;
        st = old * 64'd6364136223846793005 + (64'd1442695040888963407 | 64'd1);
        t = ((old >> 18) ^ old) >> 27;
        xs = t[31:0];
        rot = old[63:59];
        return (rot == 5'd0) ? xs : ((xs >> rot) | (xs << (6'd32 - {1'b0, rot})));
    endfunction

    // Compute one draw from a seed and queue the expected slots
    function automatic void predict_draw(input logic [63:0] seed);
        logic [63:0] st;
        logic [31:0] u;
        logic [63:0] n;
        logic [6:0]  nums[SLOTS];
        logic [6:0]  pool[POOL];
        bit          taken[POOL];
        logic [6:0]  tmp;
        int          bits;
        int          got;
        int          steps;
        int          m;
        bit          shortd;
        slot_t       s;
        bits = (cur_fam == FAM_LCG32) ? 15 : 32;
        got = 0;
        steps = 0;
        shortd = 1'b0;
        foreach (nums[i]) nums[i] = '0;
        foreach (taken[i]) taken[i] = 1'b0;
        case (cur_fam)
            FAM_LCG48: st = (seed ^ 64'h5DEECE66D) & 64'h0000_FFFF_FFFF_FFFF;
            FAM_LCG32: st = {32'd0, seed[31:0]};
            FAM_LCG31: st = seed & 64'h7FFF_FFFF;
            FAM_XS32:  st = (seed[31:0] != 0) ? {32'd0, seed[31:0]} : 64'd1;
            FAM_XS64S: st = (seed != 0) ? seed : 64'd1;
            default:   st = seed;
        endcase
        if (cur_mode == MODE_MOD_REJ || cur_mode == MODE_MUL_REJ) begin
            // draw with duplicate rejection until full or out of steps
            while (got < SLOTS && steps < LIMIT) begin
                u = (cur_fam == FAM_PCG32) ? pcg_word(st) : next_word(cur_fam, st);
                if (cur_mode == MODE_MOD_REJ)
                    n = {32'd0, u} % POOL;
                else
                    n = ({32'd0, u} * POOL) >> bits;
                steps++;
                if (n < POOL && !taken[n]) begin
                    taken[n] = 1'b1;
                    nums[got] = 7'(n + 1);
                    got++;
                end
            end
            shortd = (got < SLOTS);
        end else begin
            // partial shuffle of the pool
            foreach (pool[i]) pool[i] = 7'(i + 1);
            for (int i = 0; i < SLOTS; i++) begin
                m = POOL - i;
                u = (cur_fam == FAM_PCG32) ? pcg_word(st) : next_word(cur_fam, st);
                if (cur_mode == MODE_SHUF_MOD)
                    n = {32'd0, u} % m;
                else
                    n = ({32'd0, u} * m) >> bits;
                if (n >= m)
                    n = m - 1;
                tmp = pool[i];
                pool[i] = pool[i + n];
                pool[i + n] = tmp;
                nums[i] = pool[i];
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            s.number = nums[i];
            s.position = 5'(i);
            s.short_draw = shortd;
            s.last = (i == SLOTS - 1);
            slot_q.push_back(s);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Seed driver: predict on each transfer, then hold, refill or idle
    always @(posedge aclk) begin
        logic        nvalid;
        logic [63:0] ndata;
        nvalid = s_tvalid;
        ndata = s_tdata;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_draw(s_tdata);
                void'(seed_q.pop_front());
                nvalid = 1'b0;
            end
            if (!nvalid && seed_q.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                nvalid = 1'b1;
                ndata = seed_q[0];
            end
        end
        s_tvalid <= nvalid;
        s_tdata <= ndata;
    end

    // Result monitor: check each transfer, toggle back-pressure
    always @(posedge aclk) begin
        slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (slot_q.size() == 0) begin
                report_mismatch("unexpected result, number", m_tdata[6:0], 0);
            end else begin
                want = slot_q.pop_front();
                if (m_tdata[6:0] != want.number)
                    report_mismatch("draw_number", m_tdata[6:0], want.number);
                if (m_tdata[11:7] != want.position)
                    report_mismatch("draw_position", m_tdata[11:7], want.position);
                if (m_tdata[15:12] != 4'd0)
                    report_mismatch("tdata fill", m_tdata[15:12], 0);
                if (m_tuser != want.short_draw)
                    report_mismatch("short_draw", m_tuser, want.short_draw);
                if (m_tlast != want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
        m_tready <= aresetn && (calm || $urandom_range(99) >= 35);
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GEN_FAMILY)
            cur_fam = fam_t'(value[2:0]);
        else
            cur_mode = mode_t'(value[1:0]);
    endtask

    // Stimulus: every family with every sampler, directed seed first
    initial begin
        logic [63:0] edge_seeds[8];
        edge_seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h5DEECE66D,
                       64'h8000_0000_0000_0000, 64'h0000_0000_FFFF_FFFF,
                       64'hFFFF_FFFF_0000_0000, 64'h0000_0000_7FFF_FFFF};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 32; ph++) begin
            // wait for the block to drain before touching registers
            while (seed_q.size() > 0 || s_tvalid || slot_q.size() > 0)
                @(posedge aclk);
            repeat (4) @(posedge aclk);
            calm = (ph >= 12 && ph < 16);
            write_reg(REG_GEN_FAMILY, 32'(ph % 8));
            write_reg(REG_SAMPLER_MODE, 32'(ph / 8));
            seed_q.push_back(edge_seeds[ph % 8]);
            for (int k = 0; k < 3; k++)
                seed_q.push_back(($urandom_range(3) == 0) ? 64'($urandom_range(1000))
                                                          : {$urandom, $urandom});
        end
        while (seed_q.size() > 0 || s_tvalid || slot_q.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
